/* rtl/rmq_pkg.sv */
// Package with types, constants and helpers for the rotation matrix to quaternion block
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    // width of the signed square-root argument and of its magnitude
    localparam int AW = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 19;
    localparam int AM = AW - 1;
    // root bits, remainder bits, divider datapath bits
    localparam int SQW = (AM + FRAC_BITS + 1) / 2;
    localparam int RW = SQW + 2;
    localparam int DW = SQW + FRAC_BITS + 3;
    // width of a sum or difference of two elements, and quotient bits
    localparam int EW = 17;
    localparam int QW = FRAC_BITS + 1;
    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PW = 2;
    localparam int CW = 3;

    localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;
    localparam logic [DW-1:0] LIM_P = (ONE_D > DW'(32767)) ? DW'(32767) : ONE_D;
    localparam logic [DW-1:0] LIM_N = (ONE_D > DW'(32768)) ? DW'(32768) : ONE_D;

    // which component takes the square root
    typedef enum logic [1:0] {
        BR_W,
        BR_X,
        BR_Y,
        BR_Z
    } br_t;

    typedef struct packed {
        logic [AM-1:0]        a;
        logic [2:0][EW-1:0]   d;
        br_t                  br;
        logic                 degen;
    } item_t;

    typedef struct packed {
        br_t                  br;
        logic                 degen;
        logic [2:0]           neg;
        logic [2:0][EW-1:0]   mag;
    } meta_t;

    typedef struct packed {
        logic [CW-1:0] count;
        logic          empty;
        logic          full;
    } fifo_stat_t;

    // clamp a magnitude to one and to the 16-bit range, then apply the sign
    function automatic logic [15:0] sat16(input logic [DW-1:0] mag, input logic neg);
        logic [DW-1:0] lim;
        logic [DW-1:0] m;
        lim = neg ? LIM_N : LIM_P;
        m = (mag > lim) ? lim : mag;
        return neg ? 16'(-m) : 16'(m);
    endfunction

endpackage

/* rtl/rotation_matrix_to_quaternion_top.sv */
// Top level: rotation matrix to quaternion converter
// Each matrix passes the front register, the queue, the 16-stage square root
// and the 15-bit divider pipeline that follows it.
// Throughput one matrix per cycle; the whole back pipeline holds while a
// result waits, and the four-entry queue absorbs the front stage meanwhile.
// Reset (aresetn low, synchronous) empties the front, the queue and the pipeline.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_m00,
    input  logic signed [15:0]   s_m01,
    input  logic signed [15:0]   s_m02,
    input  logic signed [15:0]   s_m10,
    input  logic signed [15:0]   s_m11,
    input  logic signed [15:0]   s_m12,
    input  logic signed [15:0]   s_m20,
    input  logic signed [15:0]   s_m21,
    input  logic signed [15:0]   s_m22,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_qx,
    output logic signed [15:0]   m_qy,
    output logic signed [15:0]   m_qz,
    output logic signed [15:0]   m_qw,
    output logic                 m_degenerate
);
    import rmq_pkg::*;

    logic       push, pop;
    item_t      wr_item, rd_item;
    fifo_stat_t stat;

    // front stage
    rmq_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_m00      (s_m00),
        .s_m01      (s_m01),
        .s_m02      (s_m02),
        .s_m10      (s_m10),
        .s_m11      (s_m11),
        .s_m12      (s_m12),
        .s_m20      (s_m20),
        .s_m21      (s_m21),
        .s_m22      (s_m22),
        .item_valid (push),
        .item       (wr_item),
        .fifo_full  (stat.full)
    );

    // queue
    rmq_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .stat    (stat)
    );

    // arithmetic pipeline
    rmq_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fifo_empty   (stat.empty),
        .rd_item      (rd_item),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_qx         (m_qx),
        .m_qy         (m_qy),
        .m_qz         (m_qz),
        .m_qw         (m_qw),
        .m_degenerate (m_degenerate)
    );

    // queue never overfills
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= CW'(FIFO_DEPTH))
        else $error("queue fill level beyond depth");

    // no transfer out of an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    // no push into a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("push into full queue");

    // reset clears the result channel
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

/* rtl/rmq_front.sv */
// Front stage: branch selection, square-root argument and off-diagonal terms
`timescale 1ns / 1ps
module rmq_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [15:0]   s_m00,
    input  logic signed [15:0]   s_m01,
    input  logic signed [15:0]   s_m02,
    input  logic signed [15:0]   s_m10,
    input  logic signed [15:0]   s_m11,
    input  logic signed [15:0]   s_m12,
    input  logic signed [15:0]   s_m20,
    input  logic signed [15:0]   s_m21,
    input  logic signed [15:0]   s_m22,
    output logic                 item_valid,
    output rmq_pkg::item_t       item,
    input  logic                 fifo_full
);
    import rmq_pkg::*;

    localparam logic signed [AW-1:0] ONE_A = AW'(1) << FRAC_BITS;

    logic signed [AW-1:0] e00, e11, e22, trace, a_raw, a_fix;
    logic signed [EW-1:0] d0, d1, d2;
    br_t                  br;
    logic                 degen;
    logic                 vld_reg, vld_next;
    item_t                item_reg, item_next;
    logic                 take;

    // diagonal and trace
    always_comb begin
        e00 = AW'(s_m00);
        e11 = AW'(s_m11);
        e22 = AW'(s_m22);
        trace = e00 + e11 + e22;
    end

    // branch choice, ties go to the lower index
    always_comb begin
        if (trace > 0) begin
            br = BR_W;
        end else if (s_m00 < s_m11) begin
            br = (s_m11 < s_m22) ? BR_Z : BR_Y;
        end else begin
            br = (s_m00 < s_m22) ? BR_Z : BR_X;
        end
    end

    // argument and the three terms, ordered as the back reassembles them
    always_comb begin
        unique case (br)
            BR_W: begin
                a_raw = trace + ONE_A;
                d0 = EW'(s_m21) - EW'(s_m12);
                d1 = EW'(s_m02) - EW'(s_m20);
                d2 = EW'(s_m10) - EW'(s_m01);
            end
            BR_X: begin
                a_raw = e00 - e11 - e22 + ONE_A;
                d0 = EW'(s_m21) - EW'(s_m12);
                d1 = EW'(s_m10) + EW'(s_m01);
                d2 = EW'(s_m20) + EW'(s_m02);
            end
            BR_Y: begin
                a_raw = e11 - e22 - e00 + ONE_A;
                d0 = EW'(s_m02) - EW'(s_m20);
                d1 = EW'(s_m21) + EW'(s_m12);
                d2 = EW'(s_m01) + EW'(s_m10);
            end
            default: begin
                a_raw = e22 - e00 - e11 + ONE_A;
                d0 = EW'(s_m10) - EW'(s_m01);
                d1 = EW'(s_m02) + EW'(s_m20);
                d2 = EW'(s_m12) + EW'(s_m21);
            end
        endcase
        degen = (a_raw <= 0);
        a_fix = degen ? AW'(1) : a_raw;
    end

    // front register
    assign take    = vld_reg && !fifo_full;
    assign s_ready = !vld_reg || take;

    always_comb begin
        vld_next = vld_reg;
        item_next = item_reg;
        if (take) begin
            vld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
            item_next.a = a_fix[AM-1:0];
            item_next.d = {d2, d1, d0};
            item_next.br = br;
            item_next.degen = degen;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = take;
    assign item = item_reg;

endmodule

/* rtl/rmq_fifo.sv */
// Short queue between front and back
`timescale 1ns / 1ps
module rmq_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rmq_pkg::item_t       wr_item,
    input  logic                 pop,
    output rmq_pkg::item_t       rd_item,
    output rmq_pkg::fifo_stat_t  stat
);
    import rmq_pkg::*;

    item_t          mem [0:FIFO_DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item    = mem[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(FIFO_DEPTH));

endmodule

/* rtl/rmq_back.sv */
// Back pipeline: square root, reciprocal scaling, saturation and output register
`timescale 1ns / 1ps
module rmq_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fifo_empty,
    input  rmq_pkg::item_t       rd_item,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [15:0]   m_qx,
    output logic signed [15:0]   m_qy,
    output logic signed [15:0]   m_qz,
    output logic signed [15:0]   m_qw,
    output logic                 m_degenerate
);
    import rmq_pkg::*;

    logic adv;

    // square-root stages
    logic                sq_vld_reg  [0:SQW];
    logic [2*SQW-1:0]    sq_v_reg    [0:SQW];
    logic [RW-1:0]       sq_rem_reg  [0:SQW];
    logic [SQW-1:0]      sq_root_reg [0:SQW];
    meta_t               sq_meta_reg [0:SQW];

    // divider stages
    logic                dv_vld_reg  [0:QW+1];
    logic [2:0][DW-1:0]  dv_n_reg    [0:QW+1];
    logic [DW-1:0]       dv_d_reg    [0:QW+1];
    logic [2:0][QW-1:0]  dv_q_reg    [0:QW+1];
    logic [2:0]          dv_ovf_reg  [0:QW+1];
    logic [DW-1:0]       dv_main_reg [0:QW+1];
    meta_t               dv_meta_reg [0:QW+1];

    logic                out_vld_reg;
    logic [15:0]         qx_reg, qy_reg, qz_reg, qw_reg;
    logic                degen_reg;

    meta_t               meta_in;
    logic [15:0]         c0, c1, c2, cm;

    // whole pipeline moves unless the result waits
    assign adv = !out_vld_reg || m_ready;
    assign pop = adv && !fifo_empty;

    // sign and magnitude of the terms
    always_comb begin
        logic signed [EW-1:0] dv;
        meta_in.br = rd_item.br;
        meta_in.degen = rd_item.degen;
        for (int c = 0; c < 3; c++) begin
            dv = rd_item.d[c];
            meta_in.neg[c] = dv[EW-1];
            meta_in.mag[c] = dv[EW-1] ? EW'(-dv) : EW'(dv);
        end
    end

    // load from the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_vld_reg[0] <= pop;
        end
        if (adv) begin
            sq_v_reg[0]    <= (2*SQW)'({rd_item.a, {FRAC_BITS{1'b0}}});
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_meta_reg[0] <= meta_in;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < SQW; k++) begin : g_sqrt
        logic [RW+1:0] rem_sh, trial;
        logic          hit;
        always_comb begin
            rem_sh = {sq_rem_reg[k], sq_v_reg[k][2*SQW-1 -: 2]};
            trial  = {(RW-SQW)'(0), sq_root_reg[k], 2'b01};
            hit    = (rem_sh >= trial);
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (adv) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
            if (adv) begin
                sq_v_reg[k+1]    <= sq_v_reg[k] << 2;
                sq_rem_reg[k+1]  <= hit ? RW'(rem_sh - trial) : RW'(rem_sh);
                sq_root_reg[k+1] <= {sq_root_reg[k][SQW-2:0], hit};
                sq_meta_reg[k+1] <= sq_meta_reg[k];
            end
        end
    end

    // divider set-up: numerators with rounding term, divisor 2s, half of s
    always_ff @(posedge aclk) begin
        logic [DW-1:0] s;
        s = DW'(sq_root_reg[SQW]);
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[0] <= sq_vld_reg[SQW];
        end
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                dv_n_reg[0][c] <= (DW'(sq_meta_reg[SQW].mag[c]) << FRAC_BITS) + s;
            end
            dv_d_reg[0]    <= s << 1;
            dv_q_reg[0]    <= '0;
            dv_ovf_reg[0]  <= '0;
            dv_main_reg[0] <= (s + DW'(1)) >> 1;
            dv_meta_reg[0] <= sq_meta_reg[SQW];
        end
    end

    // quotient too large for the 15-bit quotient register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[1] <= 1'b0;
        end else if (adv) begin
            dv_vld_reg[1] <= dv_vld_reg[0];
        end
        if (adv) begin
            for (int c = 0; c < 3; c++) begin
                dv_ovf_reg[1][c] <= (dv_n_reg[0][c] >= (dv_d_reg[0] << QW));
            end
            dv_n_reg[1]    <= dv_n_reg[0];
            dv_d_reg[1]    <= dv_d_reg[0];
            dv_q_reg[1]    <= dv_q_reg[0];
            dv_main_reg[1] <= dv_main_reg[0];
            dv_meta_reg[1] <= dv_meta_reg[0];
        end
    end

    // one quotient bit per stage, three channels side by side
    for (genvar t = 1; t <= QW; t++) begin : g_div
        localparam int B = QW - t;
        logic [DW-1:0]      dsh;
        logic [2:0][DW-1:0] n_nx;
        logic [2:0][QW-1:0] q_nx;
        always_comb begin
            dsh = dv_d_reg[t] << B;
            n_nx = dv_n_reg[t];
            q_nx = dv_q_reg[t];
            for (int c = 0; c < 3; c++) begin
                if (dv_n_reg[t][c] >= dsh) begin
                    n_nx[c] = dv_n_reg[t][c] - dsh;
                    q_nx[c][B] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[t+1] <= 1'b0;
            end else if (adv) begin
                dv_vld_reg[t+1] <= dv_vld_reg[t];
            end
            if (adv) begin
                dv_n_reg[t+1]    <= n_nx;
                dv_d_reg[t+1]    <= dv_d_reg[t];
                dv_q_reg[t+1]    <= q_nx;
                dv_ovf_reg[t+1]  <= dv_ovf_reg[t];
                dv_main_reg[t+1] <= dv_main_reg[t];
                dv_meta_reg[t+1] <= dv_meta_reg[t];
            end
        end
    end

    // saturation
    always_comb begin
        meta_t mt;
        mt = dv_meta_reg[QW+1];
        cm = sat16(dv_main_reg[QW+1], 1'b0);
        c0 = sat16(dv_ovf_reg[QW+1][0] ? ONE_D : DW'(dv_q_reg[QW+1][0]), mt.neg[0]);
        c1 = sat16(dv_ovf_reg[QW+1][1] ? ONE_D : DW'(dv_q_reg[QW+1][1]), mt.neg[1]);
        c2 = sat16(dv_ovf_reg[QW+1][2] ? ONE_D : DW'(dv_q_reg[QW+1][2]), mt.neg[2]);
    end

    // output register, components placed by branch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_vld_reg[QW+1];
        end
        if (adv) begin
            degen_reg <= dv_meta_reg[QW+1].degen;
            unique case (dv_meta_reg[QW+1].br)
                BR_W: begin
                    qx_reg <= c0; qy_reg <= c1; qz_reg <= c2; qw_reg <= cm;
                end
                BR_X: begin
                    qx_reg <= cm; qw_reg <= c0; qy_reg <= c1; qz_reg <= c2;
                end
                BR_Y: begin
                    qy_reg <= cm; qw_reg <= c0; qz_reg <= c1; qx_reg <= c2;
                end
                default: begin
                    qz_reg <= cm; qw_reg <= c0; qx_reg <= c1; qy_reg <= c2;
                end
            endcase
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_qx         = qx_reg;
    assign m_qy         = qy_reg;
    assign m_qz         = qz_reg;
    assign m_qw         = qw_reg;
    assign m_degenerate = degen_reg;

endmodule
